[sv/ttcw_pkg.sv]
// Shared constants for the text terminal character writer: field widths,
// request opcodes and character codes. No dependencies.
package ttcw_pkg;

    // Default screen geometry
    localparam int COLUMNS_DEFAULT = 80;
    localparam int ROWS_DEFAULT    = 25;

    // Field widths of the stream payloads
    localparam int OPCODE_W   = 2;
    localparam int CHAR_W     = 8;
    localparam int CADDR_W    = 11;
    localparam int CELL_W     = 16;
    localparam int CCOL_W     = 7;
    localparam int CLINE_W    = 5;
    localparam int CPOS_W     = 11;
    localparam int S_TDATA_W  = 24;
    localparam int M_TDATA_W  = 40;

    // Request opcodes
    localparam logic [OPCODE_W-1:0] OP_PUT   = 2'd0;
    localparam logic [OPCODE_W-1:0] OP_READ  = 2'd1;
    localparam logic [OPCODE_W-1:0] OP_CLEAR = 2'd2;

    // Character and attribute codes
    localparam logic [CHAR_W-1:0] NEWLINE_CODE = 8'd10;
    localparam logic [CHAR_W-1:0] BLANK_CODE   = 8'h20;
    localparam logic [7:0]        RESET_COLOR  = 8'h07;

endpackage

[sv/text_terminal_char_writer.sv]
// Text terminal character writer: screen memory, cursor and request sequencer.
// Depends on ttcw_pkg.
//
//  channel    dir  handshake          payload
//  s_         in   s_tvalid/s_tready  tuser: opcode; tdata: char_code, cell_address
//  m_         out  m_tvalid/m_tready  tdata: cell_data, cursor_col, cursor_line,
//                                            cursor_position, did_scroll
//  text_color in   text_color_we      text_color_wdata (attribute byte)
//
// Sequencing: a read goes through the registered memory read port; a clear
// sweeps every cell and a put that scrolls moves every row up; the single
// port pair of the screen memory paces these, one cell moved per cycle.
// Reset: after aresetn the block sweeps the screen memory with grey blanks,
// with s_tready low.
// Stalls: a finished result waits in the output register while the next
// request is taken; a request finishing while that register is still full
// holds until m_tready drains it.
module text_terminal_char_writer #(
    parameter int COLUMNS = ttcw_pkg::COLUMNS_DEFAULT,
    parameter int ROWS    = ttcw_pkg::ROWS_DEFAULT
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    // configuration: text color register
    input  logic                            text_color_we,
    input  logic [7:0]                      text_color_wdata,
    // request stream
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [ttcw_pkg::S_TDATA_W-1:0]  s_tdata,  // [7:0] char_code, [18:8] cell_address
    input  logic [ttcw_pkg::OPCODE_W-1:0]   s_tuser,  // [1:0] opcode
    // result stream
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [ttcw_pkg::M_TDATA_W-1:0]  m_tdata   // [15:0] cell_data, [22:16] cursor_col,
                                                      // [27:23] cursor_line,
                                                      // [38:28] cursor_position, [39] did_scroll
);

    localparam int CELL_COUNT = COLUMNS * ROWS;
    localparam int ADDR_W     = $clog2(CELL_COUNT);
    localparam int COL_W      = $clog2(COLUMNS);
    localparam int LINE_W     = $clog2(ROWS);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_SCROLL,
        ST_DRAIN,
        ST_FILL,
        ST_EMIT
    } state_t;

    state_t                         state_reg;
    logic [ADDR_W-1:0]              scan_reg;
    logic [7:0]                     fill_color_reg;
    logic                           fill_emit_reg;
    logic                           wr_pend_reg;
    logic [ADDR_W-1:0]              wr_pend_addr_reg;
    logic [7:0]                     text_color_reg;
    logic [COL_W-1:0]               col_reg;
    logic [LINE_W-1:0]              line_reg;
    logic [ADDR_W-1:0]              pos_reg;
    logic [ttcw_pkg::CELL_W-1:0]    res_data_reg;
    logic                           res_scroll_reg;
    logic                           m_tvalid_reg;
    logic [ttcw_pkg::M_TDATA_W-1:0] m_tdata_reg;

    // Screen memory: one write port, one registered read port
    logic [ttcw_pkg::CELL_W-1:0]    screen_mem [CELL_COUNT];
    logic [ttcw_pkg::CELL_W-1:0]    rd_data_reg;

    logic                           mem_we;
    logic [ADDR_W-1:0]              mem_waddr;
    logic [ttcw_pkg::CELL_W-1:0]    mem_wdata;
    logic                           mem_re;
    logic [ADDR_W-1:0]              mem_raddr;

    // Request fields
    logic [ttcw_pkg::OPCODE_W-1:0]  req_opcode;
    logic [ttcw_pkg::CHAR_W-1:0]    req_char;
    logic [ttcw_pkg::CADDR_W-1:0]   req_addr;
    logic [31:0]                    req_addr_wide;
    logic                           req_addr_ok;
    logic                           accept;

    // Cursor advance for a put
    logic                           put_wrap;
    logic                           put_scroll;
    logic [COL_W-1:0]               col_next;
    logic [LINE_W-1:0]              line_next;
    logic [ADDR_W-1:0]              pos_next;

    // Output packing
    logic [31:0]                    col_wide;
    logic [31:0]                    line_wide;
    logic [31:0]                    pos_wide;
    logic [ttcw_pkg::M_TDATA_W-1:0] result_word;

    assign req_opcode    = s_tuser;
    assign req_char      = s_tdata[7:0];
    assign req_addr      = s_tdata[18:8];
    assign req_addr_wide = 32'(req_addr);
    assign req_addr_ok   = req_addr_wide < 32'(CELL_COUNT);

    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;

    // Newline or last column wraps; wrapping off the last row scrolls
    always_comb begin
        put_wrap   = (req_char == ttcw_pkg::NEWLINE_CODE) || (col_reg == COL_W'(COLUMNS - 1));
        put_scroll = put_wrap && (line_reg == LINE_W'(ROWS - 1));
        col_next   = col_reg + COL_W'(1);
        line_next  = line_reg;
        pos_next   = pos_reg + ADDR_W'(1);
        if (put_wrap) begin
            col_next = '0;
            if (put_scroll) begin
                pos_next = ADDR_W'(CELL_COUNT - COLUMNS);
            end else begin
                line_next = line_reg + LINE_W'(1);
                pos_next  = pos_reg + ADDR_W'(COLUMNS) - ADDR_W'(col_reg);
            end
        end
    end

    // Memory port selection: the delayed scroll write, a fill sweep, or a put
    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = pos_reg;
        mem_wdata = {text_color_reg, req_char};
        mem_re    = 1'b0;
        mem_raddr = scan_reg;
        if (wr_pend_reg) begin
            mem_we    = 1'b1;
            mem_waddr = wr_pend_addr_reg;
            mem_wdata = rd_data_reg;
        end else if (state_reg == ST_FILL) begin
            mem_we    = 1'b1;
            mem_waddr = scan_reg;
            mem_wdata = {fill_color_reg, ttcw_pkg::BLANK_CODE};
        end else if (accept && req_opcode == ttcw_pkg::OP_PUT
                     && req_char != ttcw_pkg::NEWLINE_CODE) begin
            mem_we = 1'b1;
        end
        if (state_reg == ST_SCROLL) begin
            mem_re = 1'b1;
        end else if (accept && req_opcode == ttcw_pkg::OP_READ && req_addr_ok) begin
            mem_re    = 1'b1;
            mem_raddr = req_addr_wide[ADDR_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            screen_mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re) begin
            rd_data_reg <= screen_mem[mem_raddr];
        end
    end

    // Pack the result: cursor fields masked to their port widths
    always_comb begin
        col_wide    = 32'(col_reg);
        line_wide   = 32'(line_reg);
        pos_wide    = 32'(pos_reg);
        result_word = {res_scroll_reg,
                       pos_wide[ttcw_pkg::CPOS_W-1:0],
                       line_wide[ttcw_pkg::CLINE_W-1:0],
                       col_wide[ttcw_pkg::CCOL_W-1:0],
                       res_data_reg};
    end

    // Configuration register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            text_color_reg <= ttcw_pkg::RESET_COLOR;
        end else if (text_color_we) begin
            text_color_reg <= text_color_wdata;
        end
    end

    // Request sequencer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_FILL;       // clearing pass after reset
            scan_reg       <= '0;
            fill_color_reg <= ttcw_pkg::RESET_COLOR;
            fill_emit_reg  <= 1'b0;
            wr_pend_reg    <= 1'b0;
            col_reg        <= '0;
            line_reg       <= '0;
            pos_reg        <= '0;
            m_tvalid_reg   <= 1'b0;
        end else begin
            wr_pend_reg      <= (state_reg == ST_SCROLL);
            wr_pend_addr_reg <= scan_reg - ADDR_W'(COLUMNS);
            // drop a taken result unless a new one is loaded this cycle
            if (m_tready && state_reg != ST_EMIT) begin
                m_tvalid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE: begin
                    if (accept) begin
                        res_data_reg <= '0;
                        case (req_opcode)
                            ttcw_pkg::OP_PUT: begin
                                col_reg        <= col_next;
                                line_reg       <= line_next;
                                pos_reg        <= pos_next;
                                res_scroll_reg <= put_scroll;
                                if (put_scroll) begin
                                    // move rows up, reading one row ahead of the writes
                                    scan_reg  <= ADDR_W'(COLUMNS);
                                    state_reg <= ST_SCROLL;
                                end else begin
                                    state_reg <= ST_EMIT;
                                end
                            end
                            ttcw_pkg::OP_READ: begin
                                res_scroll_reg <= 1'b0;
                                state_reg      <= req_addr_ok ? ST_READ : ST_EMIT;
                            end
                            ttcw_pkg::OP_CLEAR: begin
                                res_scroll_reg <= 1'b0;
                                scan_reg       <= '0;
                                fill_color_reg <= text_color_reg;
                                fill_emit_reg  <= 1'b1;
                                state_reg      <= ST_FILL;
                            end
                            default: begin
                                res_scroll_reg <= 1'b0;
                                state_reg      <= ST_EMIT;
                            end
                        endcase
                    end
                end
                ST_READ: begin
                    res_data_reg <= rd_data_reg;
                    state_reg    <= ST_EMIT;
                end
                ST_SCROLL: begin
                    if (scan_reg == ADDR_W'(CELL_COUNT - 1)) begin
                        state_reg <= ST_DRAIN;
                    end else begin
                        scan_reg <= scan_reg + ADDR_W'(1);
                    end
                end
                ST_DRAIN: begin
                    // last moved cell is written this cycle; then blank the bottom row
                    scan_reg       <= ADDR_W'(CELL_COUNT - COLUMNS);
                    fill_color_reg <= text_color_reg;
                    fill_emit_reg  <= 1'b1;
                    state_reg      <= ST_FILL;
                end
                ST_FILL: begin
                    if (scan_reg == ADDR_W'(CELL_COUNT - 1)) begin
                        state_reg <= fill_emit_reg ? ST_EMIT : ST_IDLE;
                    end else begin
                        scan_reg <= scan_reg + ADDR_W'(1);
                    end
                end
                ST_EMIT: begin
                    // hold until the output register is free
                    if (!m_tvalid_reg || m_tready) begin
                        m_tdata_reg  <= result_word;
                        m_tvalid_reg <= 1'b1;
                        state_reg    <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

[sv/ttcw_checker.sv]
// Port-level checks for the text terminal character writer, with its bind.
// Depends on ttcw_pkg and text_terminal_char_writer.
module ttcw_checker #(
    parameter int COLUMNS = ttcw_pkg::COLUMNS_DEFAULT,
    parameter int ROWS    = ttcw_pkg::ROWS_DEFAULT
) (
    input logic                            aclk,
    input logic                            aresetn,
    input logic                            s_tvalid,
    input logic                            s_tready,
    input logic                            m_tvalid,
    input logic                            m_tready,
    input logic [ttcw_pkg::M_TDATA_W-1:0]  m_tdata
);

    localparam bit FITS = (COLUMNS <= 128) && (ROWS <= 32);

    logic [31:0] col_wide;
    logic [31:0] line_wide;
    logic [31:0] pos_calc;

    assign col_wide  = 32'(m_tdata[22:16]);
    assign line_wide = 32'(m_tdata[27:23]);
    assign pos_calc  = line_wide * 32'(COLUMNS) + col_wide;

    // one request in flight: the request side closes right after a take
    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("request taken while another is in progress");

    a_result_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result changed or dropped");

    a_position: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !FITS || (m_tdata[38:28] == pos_calc[10:0]))
        else $error("cursor position disagrees with column and line");

    a_scroll_cursor: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[39] |-> !FITS
            || (col_wide == 32'd0 && line_wide == 32'(ROWS - 1)))
        else $error("scroll left the cursor off the last row start");

    a_cursor_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !FITS || (col_wide < 32'(COLUMNS) && line_wide < 32'(ROWS)))
        else $error("cursor out of screen");

endmodule

bind text_terminal_char_writer ttcw_checker #(
    .COLUMNS(COLUMNS),
    .ROWS   (ROWS)
) u_ttcw_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata)
);
